// ===== hdl/tdlf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdlf_pkg
// Shared constants, types and helpers for the tape directory length fix-up.
// ---------------------------------------------------------------------------
package tdlf_pkg;

  localparam int MaxRecords   = 64;
  localparam int AddressSpace = 65536;
  localparam int IdxW         = $clog2(MaxRecords);
  localparam int CntW         = IdxW + 1;

  localparam logic [31:0] HeaderBytes = 32'h40;
  localparam logic [15:0] LenMax      = 16'hFFFF;
  localparam logic [15:0] AddrTop     = 16'(AddressSpace - 1);
  localparam logic [7:0]  TypeLoad    = 8'd1;

  localparam logic [1:0] RegImageSize = 2'd0;
  localparam logic [1:0] RegCapacity  = 2'd1;
  localparam logic [1:0] RegUsed      = 2'd2;

  // one record as held in the tables
  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] start;
    logic [15:0] len;
  } rec_t;

  // one result beat
  typedef struct packed {
    logic        status;
    logic [5:0]  entry_number;
    logic [15:0] start_address;
    logic [15:0] true_length;
    logic [8:0]  block_count;
    logic        run_end;
  } res_t;

  // ceil(len / 254) via reciprocal multiply and one correction step
  function automatic logic [8:0] blocks_of(input logic [15:0] len);
    logic [16:0] a;
    logic [33:0] p;
    logic [8:0]  q;
    logic [16:0] r;
    a = {1'b0, len} + 17'd253;
    p = 34'(a) * 34'd66052;   // floor(2^24 / 254), quotient never too high
    q = 9'(p >> 24);
    r = a - 17'(q) * 17'd254;
    if (r >= 17'd254) q = q + 9'd1;
    return q;
  endfunction

endpackage

// ===== hdl/tdlf_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdlf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tdlf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/tdlf_seq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdlf_seq
// Sequencer: record intake, insertion sort of offsets with one shared
// compare, then length fix-up and result emission, one table read at a time.
// ---------------------------------------------------------------------------
module tdlf_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         image_size,
  input  logic [15:0]         header_capacity,
  input  logic [15:0]         header_used,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          entry_type,
  input  logic [15:0]         load_address,
  input  logic [15:0]         stated_end,
  input  logic [31:0]         data_offset,
  input  logic                final_entry,
  output logic                out_valid,
  input  logic                out_stall,
  output tdlf_pkg::res_t      res
);
  import tdlf_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SORTI = 12'b000000000010,
    S_SORTV = 12'b000000000100,
    S_SORTR = 12'b000000001000,
    S_SORTA = 12'b000000010000,
    S_SORTC = 12'b000000100000,
    S_FIXA  = 12'b000001000000,
    S_FIXB  = 12'b000010000000,
    S_FIXC  = 12'b000100000000,
    S_FIXD  = 12'b001000000000,
    S_OUTR  = 12'b010000000000,
    S_OUTW  = 12'b100000000000
  } state_t;

  state_t state;
  logic [CntW-1:0] kept_count;
  logic [15:0]     records_seen;
  logic [CntW-1:0] i;
  logic [CntW-1:0] j;
  logic [31:0]     v_off;
  logic [IdxW-1:0] p_idx;
  logic [IdxW-1:0] cur_k;
  rec_t            cur_rec;
  logic            out_full;
  res_t            res_q;

  // record table and order table
  logic            rec_we;
  logic [IdxW-1:0] rec_wa, rec_ra;
  rec_t            rec_wd, rec_rd;
  logic            ord_we;
  logic [IdxW-1:0] ord_wa, ord_ra;
  logic [IdxW-1:0] ord_wd, ord_rd;

  tdlf_ram #(.Width($bits(rec_t)), .Depth(MaxRecords)) u_rec (
    .clk, .we(rec_we), .waddr(rec_wa), .wdata(rec_wd), .raddr(rec_ra), .rdata(rec_rd)
  );
  tdlf_ram #(.Width(IdxW), .Depth(MaxRecords)) u_ord (
    .clk, .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd)
  );

  // record limit
  logic [15:0] cap, used, lim;
  logic [31:0] room;
  logic        size_ok, keep, reject;
  logic [15:0] stated_len;
  always_comb begin
    cap  = (header_capacity == 16'd0) ? 16'd1 : header_capacity;
    used = (header_used == 16'd0) ? 16'd1 : header_used;
    if (used > cap) used = cap;
    room = (image_size - HeaderBytes) >> 5;
    lim  = ({16'd0, used} > room) ? room[15:0] : used;
    size_ok = image_size >= HeaderBytes;
    keep = size_ok && (records_seen < lim) && (entry_type == TypeLoad) &&
           (data_offset < image_size) && (kept_count < CntW'(MaxRecords));
    reject = !size_ok || (kept_count == '0 && !keep);
    stated_len = (stated_end > load_address) ? stated_end - load_address : 16'd0;
  end

  logic accept;
  assign in_stall  = (state != S_IDLE) || out_full;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_full;
  assign res       = res_q;

  // current walk position is the last kept record
  logic last;
  assign last = (i + CntW'(1) == kept_count);

  // sort compare: previous slot holds a larger offset
  logic shift;
  assign shift = rec_rd.offset > v_off;

  // fix-up arithmetic on the current record
  logic [31:0] nxt, gap;
  logic [15:0] slen, nlen, rm;
  always_comb begin
    nxt  = last ? image_size : rec_rd.offset;
    gap  = (nxt > cur_rec.offset) ? nxt - cur_rec.offset : 32'd0;
    slen = cur_rec.len;
    rm   = AddrTop - cur_rec.start;
    nlen = slen;
    if ({16'd0, slen} != gap && !(last && {16'd0, slen} < gap && slen != 16'd0))
      nlen = (gap > {16'd0, LenMax}) ? LenMax : gap[15:0];
    if (nlen > rm) nlen = rm;
  end

  // result beats
  res_t rej_beat, ent_beat;
  logic slot_free, load_beat;
  always_comb begin
    rej_beat = '0;
    rej_beat.status = 1'b1;
    rej_beat.run_end = 1'b1;
    ent_beat = '0;
    ent_beat.entry_number  = i[IdxW-1:0];
    ent_beat.start_address = rec_rd.start;
    ent_beat.true_length   = rec_rd.len;
    ent_beat.block_count   = blocks_of(rec_rd.len);
    ent_beat.run_end       = last;
    slot_free = !out_full || !out_stall;
    load_beat = (state == S_IDLE && accept && final_entry && reject) ||
                (state == S_OUTW && slot_free);
  end

  // ram port drive
  always_comb begin
    rec_we = 1'b0;
    rec_wa = kept_count[IdxW-1:0];
    rec_wd = '0;
    rec_ra = i[IdxW-1:0];
    ord_we = 1'b0;
    ord_wa = j[IdxW-1:0];
    ord_wd = i[IdxW-1:0];
    ord_ra = i[IdxW-1:0];
    case (state)
      S_IDLE: begin
        rec_we = accept && keep;
        rec_wd.offset = data_offset;
        rec_wd.start  = load_address;
        rec_wd.len    = stated_len;
      end
      S_SORTR: begin
        ord_ra = IdxW'(j - CntW'(1));
        ord_we = (j == '0);
      end
      S_SORTA: rec_ra = ord_rd;
      S_SORTC: begin
        ord_we = 1'b1;
        if (shift) ord_wd = p_idx;
      end
      S_FIXB: begin
        rec_ra = ord_rd;
        ord_ra = IdxW'(i + CntW'(1));
      end
      S_FIXC: rec_ra = ord_rd;
      S_FIXD: begin
        rec_we = 1'b1;
        rec_wa = cur_k;
        rec_wd = cur_rec;
        rec_wd.len = nlen;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kept_count <= '0;
      records_seen <= '0;
      out_full <= 1'b0;
      i <= '0;
      j <= '0;
    end else begin
      out_full <= load_beat || (out_full && out_stall);
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (final_entry) begin
              records_seen <= '0;
              i <= '0;
              if (reject) begin
                kept_count <= '0;
                res_q <= rej_beat;
              end else begin
                kept_count <= kept_count + {{IdxW{1'b0}}, keep};
                state <= S_SORTI;
              end
            end else begin
              kept_count <= kept_count + {{IdxW{1'b0}}, keep};
              if (records_seen != 16'hFFFF) records_seen <= records_seen + 16'd1;
            end
          end
        end
        S_SORTI: state <= S_SORTV;
        S_SORTV: begin
          v_off <= rec_rd.offset;
          j <= i;
          state <= S_SORTR;
        end
        S_SORTR: begin
          if (j != '0) begin
            state <= S_SORTA;
          end else if (last) begin
            i <= '0;
            state <= S_FIXA;
          end else begin
            i <= i + CntW'(1);
            state <= S_SORTI;
          end
        end
        S_SORTA: begin
          p_idx <= ord_rd;
          state <= S_SORTC;
        end
        S_SORTC: begin
          // shift one slot up, or place the record
          if (shift) begin
            j <= j - CntW'(1);
            state <= S_SORTR;
          end else if (last) begin
            i <= '0;
            state <= S_FIXA;
          end else begin
            i <= i + CntW'(1);
            state <= S_SORTI;
          end
        end
        S_FIXA: state <= S_FIXB;
        S_FIXB: begin
          cur_k <= ord_rd;
          state <= S_FIXC;
        end
        S_FIXC: begin
          cur_rec <= rec_rd;
          state <= S_FIXD;
        end
        S_FIXD: begin
          if (last) begin
            i <= '0;
            state <= S_OUTR;
          end else begin
            i <= i + CntW'(1);
            state <= S_FIXA;
          end
        end
        S_OUTR: state <= S_OUTW;
        S_OUTW: begin
          if (slot_free) begin
            res_q <= ent_beat;
            if (last) begin
              kept_count <= '0;
              state <= S_IDLE;
            end else begin
              i <= i + CntW'(1);
              state <= S_OUTR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/tape_directory_length_fixup.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tape_directory_length_fixup
// Keeps loadable tape directory records, orders them by offset and fixes
// their lengths; emits one result beat per kept record or one reject beat.
// ---------------------------------------------------------------------------
// Usage: write image_size, header_capacity, header_used through the config
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while the block idles.
// Records come in on in_valid/in_stall, one beat each, one record per cycle
// while no results are pending. The beat with final_entry starts the
// post-pass: an insertion sort over the record table with one shared offset
// compare, shifting each order slot that holds a larger offset up and then
// placing the record; then a fix-up walk that reads each record and its
// successor's offset and writes back the fixed length; then an output walk
// of one result beat per kept record. A reject beat shows in the cycle
// after the final beat. in_stall stays high from the final beat until the
// last result beat is taken. When the receiver stalls the result beat holds
// and the walk waits. Reset (rst, synchronous) clears counts and control;
// table contents are not cleared.
// ---------------------------------------------------------------------------
module tape_directory_length_fixup (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  entry_type,
  input  logic [15:0] load_address,
  input  logic [15:0] stated_end,
  input  logic [31:0] data_offset,
  input  logic        final_entry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [5:0]  entry_number,
  output logic [15:0] start_address,
  output logic [15:0] true_length,
  output logic [8:0]  block_count,
  output logic        run_end
);
  import tdlf_pkg::*;

  logic [31:0] image_size;
  logic [15:0] header_capacity, header_used;
  res_t        res;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= '0;
      header_capacity <= '0;
      header_used <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegImageSize: image_size <= cfg_data;
        RegCapacity:  header_capacity <= cfg_data[15:0];
        RegUsed:      header_used <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  tdlf_seq u_seq (
    .clk, .rst, .image_size, .header_capacity, .header_used,
    .in_valid, .in_stall, .entry_type, .load_address, .stated_end,
    .data_offset, .final_entry, .out_valid, .out_stall, .res
  );

  assign status        = res.status;
  assign entry_number  = res.entry_number;
  assign start_address = res.start_address;
  assign true_length   = res.true_length;
  assign block_count   = res.block_count;
  assign run_end       = res.run_end;
endmodule

// ===== hdl/tdlf_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdlf_checker
// Port-level checks for the tape directory length fix-up.
// ---------------------------------------------------------------------------
module tdlf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       status,
  input logic       run_end,
  input logic [8:0] block_count,
  input logic [15:0] true_length
);
  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(true_length))
    else $error("result beat changed under stall");

  // a reject beat always closes the run
  a_rej: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> run_end)
    else $error("reject without run end");

  // no input taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // block count zero only for zero length
  a_blk: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> ((block_count == 9'd0) == (true_length == 16'd0)))
    else $error("block count mismatch");
endmodule

bind tape_directory_length_fixup tdlf_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .status, .run_end, .block_count, .true_length
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives tape directory records and register settings into the length
// fix-up block and checks every result beat against a local prediction of
// kept records, offset ordering, length fix-up, address clip and rejects.
// ---------------------------------------------------------------------------
module testbench;
  import tdlf_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int HoldCycles = 600;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  entry_type;
  logic [15:0] load_address;
  logic [15:0] stated_end;
  logic [31:0] data_offset;
  logic        final_entry;
  logic        out_valid;
  logic        out_stall;
  logic        status;
  logic [5:0]  entry_number;
  logic [15:0] start_address;
  logic [15:0] true_length;
  logic [8:0]  block_count;
  logic        run_end;

  tape_directory_length_fixup u_dut (.*);

  // register copies and directory tables of the predictor
  logic [31:0] img_size;
  logic [15:0] hdr_cap;
  logic [15:0] hdr_used;
  logic [31:0] kept_off[MaxRecords];
  logic [15:0] kept_start[MaxRecords];
  logic [15:0] kept_len[MaxRecords];
  int          kept_n;
  int unsigned seen_count;

  res_t expected_entries[$];
  int   errors;
  int   cycles;
  bit   quiet;
  bit   hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [31:0] record_limit();
    logic [31:0] cap_v;
    logic [31:0] used_v;
    logic [31:0] room;
    cap_v = (hdr_cap == 0) ? 32'd1 : {16'd0, hdr_cap};
    used_v = (hdr_used == 0) ? 32'd1 : {16'd0, hdr_used};
    room = (img_size - HeaderBytes) / 32'h20;
    if (used_v > cap_v) used_v = cap_v;
    if (used_v > room) used_v = room;
    return used_v;
  endfunction

  // predicted effect of one accepted record
  function automatic void predict_directory(input logic [7:0] typ, input logic [15:0] st,
                                            input logic [15:0] en, input logic [31:0] off,
                                            input logic fin);
    int          order[MaxRecords];
    int          n;
    int          j;
    int          v;
    logic [31:0] nxt;
    logic [31:0] actual;
    logic [31:0] len;
    logic [31:0] room;
    bit          last;
    res_t        r;
    bit          size_ok;
    size_ok = img_size >= HeaderBytes;
    if (size_ok && seen_count < record_limit() && typ == TypeLoad && off < img_size &&
        kept_n < MaxRecords) begin
      kept_off[kept_n] = off;
      kept_start[kept_n] = st;
      kept_len[kept_n] = en > st ? en - st : 16'd0;
      kept_n++;
    end
    if (seen_count < 32'hFFFF) seen_count++;
    if (!fin) return;
    n = kept_n;
    if (!size_ok || n == 0) begin
      r = '0;
      r.status = 1'b1;
      r.run_end = 1'b1;
      expected_entries = {expected_entries, r};
    end else begin
      // stable order by offset
      for (int i = 0; i < n; i++) begin
        v = i;
        j = i;
        while (j > 0 && kept_off[order[j-1]] > kept_off[v]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
      // gap fix-up and address clip
      for (int i = 0; i < n; i++) begin
        last = (i == n - 1);
        nxt = last ? img_size : kept_off[order[i+1]];
        actual = nxt > kept_off[order[i]] ? nxt - kept_off[order[i]] : 0;
        len = kept_len[order[i]];
        room = 32'hFFFF - kept_start[order[i]];
        if (len != actual && !(last && len < actual && len != 0))
          len = actual > 32'hFFFF ? 32'hFFFF : actual;
        if (len > room) len = room;
        kept_len[order[i]] = len[15:0];
      end
      for (int i = 0; i < n; i++) begin
        r.status = 1'b0;
        r.entry_number = i[5:0];
        r.start_address = kept_start[i];
        r.true_length = kept_len[i];
        r.block_count = 9'((32'(kept_len[i]) + 253) / 254);
        r.run_end = (i == n - 1);
        expected_entries = {expected_entries, r};
      end
    end
    kept_n = 0;
    seen_count = 0;
  endfunction

  // send one record beat
  task automatic send_record(input logic [7:0] typ, input logic [15:0] st,
                             input logic [15:0] en, input logic [31:0] off, input logic fin);
    in_valid <= 1'b1;
    entry_type <= typ;
    load_address <= st;
    stated_end <= en;
    data_offset <= off;
    final_entry <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_directory(typ, st, en, off, fin);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // write all registers once the block has drained
  task automatic set_regs(input logic [31:0] sz, input logic [15:0] cap_v,
                          input logic [15:0] used_v);
    logic [31:0] vals[3];
    in_valid <= 1'b0;
    wait (expected_entries.size() == 0);
    repeat (20) @(posedge clk);
    vals[0] = sz;
    vals[1] = {16'd0, cap_v};
    vals[2] = {16'd0, used_v};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    img_size = sz;
    hdr_cap = cap_v;
    hdr_used = used_v;
  endtask

  // random run of records with mostly loadable entries below the image size
  task automatic random_run(input int count);
    logic [7:0]  typ;
    logic [15:0] st;
    logic [15:0] en;
    logic [31:0] off;
    for (int i = 0; i < count; i++) begin
      typ = ($urandom_range(0, 9) < 8) ? TypeLoad : 8'($urandom);
      st = 16'($urandom);
      en = ($urandom_range(0, 1) == 1) ? 16'($urandom) : st + 16'($urandom_range(0, 3000));
      if (img_size != 0 && $urandom_range(0, 9) < 8)
        off = $urandom_range(0, img_size - 1);
      else
        off = $urandom;
      send_record(typ, st, en, off, i == count - 1);
    end
  endtask

  task automatic random_regs();
    logic [31:0] sz;
    logic [15:0] c;
    logic [15:0] u;
    case ($urandom_range(0, 9))
      0: sz = $urandom_range(0, 63);
      1: sz = 32'hFFFF_FFFF;
      2: sz = $urandom;
      3, 4: sz = $urandom_range(64, 300000);
      default: sz = $urandom_range(64, 4096);
    endcase
    c = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    u = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    set_regs(sz, c, u);
  endtask

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_entries.size() == 0) begin
        $display("unexpected result beat at cycle %0d", cycles);
        errors++;
      end else begin
        e = expected_entries.pop_front();
        if (status != e.status) report("status", status, e.status);
        if (entry_number != e.entry_number) report("entry_number", entry_number, e.entry_number);
        if (start_address != e.start_address)
          report("start_address", start_address, e.start_address);
        if (true_length != e.true_length) report("true_length", true_length, e.true_length);
        if (block_count != e.block_count) report("block_count", block_count, e.block_count);
        if (run_end != e.run_end) report("run_end", run_end, e.run_end);
      end
    end
  end

  // receiver stall bursts and the long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // field extremes, ties, drops, clip, saturation and last-record rule
  task automatic test_directed();
    set_regs(32'h1000, 16'd16, 16'd16);
    send_record(TypeLoad, 16'h0801, 16'h0901, 32'h400, 1'b0);
    send_record(TypeLoad, 16'hFFFF, 16'h0000, 32'h200, 1'b0);  // clipped to zero room
    send_record(TypeLoad, 16'h0000, 16'hFFFF, 32'h400, 1'b0);  // tie on offset
    send_record(8'h00, 16'h1000, 16'h2000, 32'h100, 1'b0);     // wrong type
    send_record(8'hFF, 16'h1000, 16'h2000, 32'h100, 1'b0);
    send_record(TypeLoad, 16'h1000, 16'h2000, 32'h1000, 1'b0); // offset at size
    send_record(TypeLoad, 16'hC000, 16'hC010, 32'hF00, 1'b1);  // last keeps short length
    // every record dropped
    send_record(8'h02, 16'h1234, 16'h5678, 32'h10, 1'b1);
    // huge image: lengths saturate
    set_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_record(TypeLoad, 16'h0001, 16'h0100, 32'h0, 1'b0);
    send_record(TypeLoad, 16'h0002, 16'h0002, 32'hFFFF_FFFE, 1'b0);
    send_record(TypeLoad, 16'h0003, 16'h0003, 32'hFFFF_FFFF, 1'b1);
    // image too small
    set_regs(32'd63, 16'd4, 16'd4);
    send_record(TypeLoad, 16'h0801, 16'h0900, 32'h0, 1'b1);
    // zero counts act as one, room limit
    set_regs(32'd64, 16'd0, 16'd0);
    send_record(TypeLoad, 16'h0801, 16'h0900, 32'h0, 1'b0);
    send_record(TypeLoad, 16'h0801, 16'h0900, 32'h1, 1'b1);
    set_regs(32'd200, 16'd0, 16'd0);
    send_record(TypeLoad, 16'h0801, 16'h0803, 32'h10, 1'b0);
    send_record(TypeLoad, 16'h0801, 16'h0900, 32'h20, 1'b1);
  endtask

  // more records than the table holds
  task automatic test_table_full();
    set_regs(32'h0010_0000, 16'hFFFF, 16'hFFFF);
    random_run(70);
  endtask

  // long receiver hold while the next run is offered
  task automatic test_backpressure();
    set_regs(32'h8000, 16'd40, 16'd40);
    hold_req = 1'b1;
    random_run(8);
    random_run(12);
    random_run(5);
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 190) begin
      if (sent > 150) quiet = 1'b1;
      if ($urandom_range(0, 2) == 0) random_regs();
      else if (img_size < 64 || record_limit() == 0) random_regs();
      n = $urandom_range(1, 10);
      random_run(n);
      sent += n;
    end
  endtask

  initial begin
    errors = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    seen_count = 0;
    kept_n = 0;
    img_size = '0;
    hdr_cap = '0;
    hdr_used = '0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    entry_type = '0;
    load_address = '0;
    stated_end = '0;
    data_offset = '0;
    final_entry = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    wait (expected_entries.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
